### design/esc_tcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_tcs_pkg
// Shared types, codes and sequence tables of the throttle command sequencer.
// ----------------------------------------------------------------------------
package esc_tcs_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 8;
  localparam int unsigned SCALE_LATENCY       = 5;
  localparam int unsigned STEP_W              = 3;
  localparam int unsigned CFG_INDEX_W         = 3;
  localparam int unsigned CFG_DATA_W          = 32;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_DEADZONE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRANSITION   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLOSED_MAX   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLOSED_FLOOR = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_OPEN_MAX     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_OPEN_CEILING = 3'd5;

  localparam logic [6:0]  DEADZONE_RESET     = 7'd2;
  localparam logic [6:0]  TRANSITION_RESET   = 7'd13;
  localparam logic [31:0] CLOSED_MAX_RESET   = 32'd229376000;
  localparam logic [31:0] CLOSED_FLOOR_RESET = 32'd20588724;
  localparam logic [31:0] OPEN_MAX_RESET     = 32'd11244405;
  localparam logic [31:0] OPEN_CEILING_RESET = 32'd1405551;

  // frame codes
  localparam logic [7:0] FRAME_SYNC      = 8'h89;
  localparam logic [7:0] CMD_MOTOR_CTRL  = 8'h08;
  localparam logic [7:0] CMD_PARAM_WRITE = 8'h06;
  localparam logic [7:0] PID_NONE        = 8'h00;
  localparam logic [7:0] PID_OL_SET      = 8'h0C;
  localparam logic [7:0] PID_CL_SET      = 8'h0E;
  localparam logic [7:0] PID_REVERSE     = 8'h63;
  localparam logic [7:0] PID_AUTO_SWITCH = 8'h76;

  localparam logic [7:0] MAG_LIMIT = 8'd100;

  // exact divide by 100 for values below 2**24: ceil(2**31 / 100)
  localparam logic [24:0]  RECIP_100   = 25'd21474837;
  localparam int unsigned  RECIP_SHIFT = 31;
  localparam logic [23:0]  ROUND_HALF  = 24'd50;
  localparam logic [23:0]  DIV_BASE    = 24'd100;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [1:0] {
    RANGE_OFF    = 2'd0,
    RANGE_OPEN   = 2'd1,
    RANGE_CLOSED = 2'd2
  } range_t;

  typedef enum logic [2:0] {
    KIND_SET        = 3'd0,
    KIND_REV_SAME   = 3'd1,
    KIND_START      = 3'd2,
    KIND_STOP       = 3'd3,
    KIND_SWITCH_REV = 3'd4,
    KIND_TO_CLOSED  = 3'd5,
    KIND_TO_OPEN    = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    OP_DISABLE = 3'd0,
    OP_AUTO    = 3'd1,
    OP_DIR     = 3'd2,
    OP_OL      = 3'd3,
    OP_CL      = 3'd4,
    OP_ENABLE  = 3'd5
  } op_t;

  typedef struct packed {
    logic [6:0]  deadzone;
    logic [6:0]  transition;
    logic [31:0] closed_max;
    logic [31:0] closed_floor;
    logic [31:0] open_max;
    logic [31:0] open_ceiling;
  } cfg_t;

  typedef struct packed {
    logic   dir;
    range_t rng;
    kind_t  kind;
  } desc_t;

  typedef struct packed {
    desc_t       desc;
    logic [31:0] ol;
    logic [31:0] cl;
  } queue_entry_t;

  // command word at a given position of a sequence
  function automatic op_t seq_op(kind_t kind, step_t step);
    op_t list [2**STEP_W];
    foreach (list[i]) list[i] = OP_DISABLE;
    unique case (kind)
      KIND_SET: begin
        list[0] = OP_OL;  list[1] = OP_CL;
      end
      KIND_REV_SAME: begin
        list[0] = OP_DISABLE; list[1] = OP_OL; list[2] = OP_CL;
        list[3] = OP_DIR;     list[4] = OP_ENABLE;
      end
      KIND_START: begin
        list[0] = OP_AUTO; list[1] = OP_DIR; list[2] = OP_OL;
        list[3] = OP_CL;   list[4] = OP_ENABLE;
      end
      KIND_STOP: begin
        list[0] = OP_DISABLE;
      end
      KIND_SWITCH_REV: begin
        list[0] = OP_DISABLE; list[1] = OP_AUTO; list[2] = OP_OL;
        list[3] = OP_CL;      list[4] = OP_DIR;  list[5] = OP_ENABLE;
      end
      KIND_TO_CLOSED: begin
        list[0] = OP_OL;   list[1] = OP_CL;
        list[2] = OP_AUTO; list[3] = OP_ENABLE;
      end
      KIND_TO_OPEN: begin
        list[0] = OP_DISABLE; list[1] = OP_AUTO; list[2] = OP_OL;
        list[3] = OP_CL;      list[4] = OP_ENABLE;
      end
      default: ;
    endcase
    return list[step];
  endfunction

  // number of command words of a sequence
  function automatic step_t seq_len(kind_t kind);
    step_t len;
    unique case (kind)
      KIND_SET:        len = 3'd2;
      KIND_REV_SAME:   len = 3'd5;
      KIND_START:      len = 3'd5;
      KIND_STOP:       len = 3'd1;
      KIND_SWITCH_REV: len = 3'd6;
      KIND_TO_CLOSED:  len = 3'd4;
      KIND_TO_OPEN:    len = 3'd5;
      default:         len = 3'd1;
    endcase
    return len;
  endfunction

endpackage

### design/esc_tcs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_tcs_in_if
// Throttle item channel: valid/ready handshake with a signed percent.
// ----------------------------------------------------------------------------
interface esc_tcs_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] throttle_percent;

  modport source (output valid, output throttle_percent, input ready);
  modport sink   (input valid, input throttle_percent, output ready);
endinterface

### design/esc_tcs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_tcs_out_if
// Command word channel: valid/ready handshake with one framed ESC command.
// ----------------------------------------------------------------------------
interface esc_tcs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  command_code;
  logic [7:0]  parameter_code;
  logic [31:0] data_word;
  logic [7:0]  frame_checksum;
  logic        last_command;

  modport source (output valid, output command_code, output parameter_code,
                  output data_word, output frame_checksum, output last_command,
                  input ready);
  modport sink   (input valid, input command_code, input parameter_code,
                  input data_word, input frame_checksum, input last_command,
                  output ready);
endinterface

### design/esc_tcs_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_tcs_scale
// Five-stage pipeline computing round(mag * maxv / 100) exactly for mag up to 100.
// ----------------------------------------------------------------------------
module esc_tcs_scale (
  input  logic        clk,
  input  logic [6:0]  mag,
  input  logic [31:0] maxv,
  output logic [31:0] q
);
  import esc_tcs_pkg::*;

  logic [22:0] a1, l1, a2, l2;
  logic [47:0] pa;
  logic [15:0] qa3, qa4;
  logic [23:0] b3;
  logic [48:0] pb;

  logic [16:0] qa_full;
  logic [23:0] qa_x100;
  logic [23:0] ra_wide;
  logic [6:0]  ra;
  logic [23:0] b_next;

  // split product: mag*maxv = a*2^16 + l, a = 100*qa + ra
  always_comb begin
    qa_full = pa[RECIP_SHIFT +: 17];
    qa_x100 = 24'(qa_full) * DIV_BASE;
    ra_wide = {1'b0, a2} - qa_x100;
    ra      = ra_wide[6:0];
    b_next  = 24'({ra, 16'h0000}) + {1'b0, l2} + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    a1  <= 23'(mag) * 23'(maxv[31:16]);
    l1  <= 23'(mag) * 23'(maxv[15:0]);
    pa  <= 48'(a1) * 48'(RECIP_100);
    a2  <= a1;
    l2  <= l1;
    qa3 <= qa_full[15:0];
    b3  <= b_next;
    pb  <= 49'(b3) * 49'(RECIP_100);
    qa4 <= qa3;
    q   <= {qa4, 16'h0000} + 32'(pb[RECIP_SHIFT +: 18]);
  end

endmodule

### design/esc_tcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_tcs_front
// Accepts throttle items, classifies range and direction change, tracks the
// previous state and scales both setpoints before queueing the sequence.
// ----------------------------------------------------------------------------
module esc_tcs_front #(
  parameter int unsigned QUEUE_DEPTH = esc_tcs_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  esc_tcs_in_if.sink                 throttle_in,
  input  esc_tcs_pkg::cfg_t          cfg,
  input  logic                       pop,
  output logic                       push,
  output esc_tcs_pkg::queue_entry_t  entry
);
  import esc_tcs_pkg::*;

  localparam int unsigned CREDIT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LAST     = SCALE_LATENCY - 1;

  logic [CREDIT_W-1:0] credit, credit_next;
  logic                dir_prev;
  range_t              range_prev;

  logic                tap_valid [SCALE_LATENCY];
  desc_t               tap_desc  [SCALE_LATENCY];

  logic [7:0]  raw;
  logic [7:0]  mag_abs;
  logic        mag_ok;
  logic        dir_now;
  logic        reversed;
  range_t      range_now;
  kind_t       kind_now;
  logic        has_words;
  logic        accept;
  logic        launch;
  logic [31:0] q_ol, q_cl;
  desc_t       desc_now;

  assign throttle_in.ready = (credit != '0);
  assign accept            = throttle_in.valid && throttle_in.ready;

  always_comb begin
    raw      = $unsigned(throttle_in.throttle_percent);
    dir_now  = raw[7];
    mag_abs  = dir_now ? 8'(8'd0 - raw) : raw;
    mag_ok   = (mag_abs <= MAG_LIMIT);
    reversed = (dir_now != dir_prev);

    if (mag_abs < {1'b0, cfg.deadzone}) begin
      range_now = RANGE_OFF;
    end else if (mag_abs < {1'b0, cfg.transition}) begin
      range_now = RANGE_OPEN;
    end else begin
      range_now = RANGE_CLOSED;
    end

    has_words = 1'b1;
    if (range_now == range_prev) begin
      kind_now  = reversed ? KIND_REV_SAME : KIND_SET;
      has_words = (range_now != RANGE_OFF);
    end else if (range_prev == RANGE_OFF) begin
      kind_now = KIND_START;
    end else if (range_now == RANGE_OFF) begin
      kind_now = KIND_STOP;
    end else if (reversed) begin
      kind_now = KIND_SWITCH_REV;
    end else if (range_now == RANGE_CLOSED) begin
      kind_now = KIND_TO_CLOSED;
    end else begin
      kind_now = KIND_TO_OPEN;
    end

    desc_now.dir  = dir_now;
    desc_now.rng  = range_now;
    desc_now.kind = kind_now;

    launch      = accept && mag_ok && has_words;
    credit_next = credit - CREDIT_W'(launch) + CREDIT_W'(pop);
  end

  esc_tcs_scale u_scale_ol (
    .clk  (clk),
    .mag  (mag_abs[6:0]),
    .maxv (cfg.open_max),
    .q    (q_ol)
  );

  esc_tcs_scale u_scale_cl (
    .clk  (clk),
    .mag  (mag_abs[6:0]),
    .maxv (cfg.closed_max),
    .q    (q_cl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      credit     <= CREDIT_W'(QUEUE_DEPTH);
      dir_prev   <= 1'b0;
      range_prev <= RANGE_OFF;
      foreach (tap_valid[i]) tap_valid[i] <= 1'b0;
    end else begin
      credit       <= credit_next;
      tap_valid[0] <= launch;
      for (int i = 1; i < SCALE_LATENCY; i++) begin
        tap_valid[i] <= tap_valid[i-1];
      end
      if (accept && mag_ok) begin
        dir_prev   <= dir_now;
        range_prev <= range_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    tap_desc[0] <= desc_now;
    for (int i = 1; i < SCALE_LATENCY; i++) begin
      tap_desc[i] <= tap_desc[i-1];
    end
  end

  // clamp setpoints, zero when off
  always_comb begin
    push       = tap_valid[LAST];
    entry.desc = tap_desc[LAST];
    if (tap_desc[LAST].rng == RANGE_OFF) begin
      entry.ol = '0;
      entry.cl = '0;
    end else begin
      entry.ol = (q_ol > cfg.open_ceiling) ? cfg.open_ceiling : q_ol;
      entry.cl = (q_cl < cfg.closed_floor) ? cfg.closed_floor : q_cl;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    credit <= CREDIT_W'(QUEUE_DEPTH))
    else $error("credit count above queue depth");

  assert property (@(posedge clk) disable iff (rst)
    pop |-> credit != CREDIT_W'(QUEUE_DEPTH))
    else $error("sequence retired with nothing in flight");

  assert property (@(posedge clk) disable iff (rst)
    accept && !mag_ok |=> dir_prev == $past(dir_prev) && range_prev == $past(range_prev))
    else $error("out-of-range throttle item changed state");

endmodule

### design/esc_tcs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_tcs_queue
// Short FIFO of classified, scaled sequences between front and back.
// ----------------------------------------------------------------------------
module esc_tcs_queue #(
  parameter int unsigned DEPTH = esc_tcs_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  esc_tcs_pkg::queue_entry_t  entry,
  input  logic                       pop,
  output logic                       head_valid,
  output esc_tcs_pkg::queue_entry_t  head
);
  import esc_tcs_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  queue_entry_t     slots [DEPTH];
  logic [IDX_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [IDX_W-1:0] ptr_inc(logic [IDX_W-1:0] p);
    return (p == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(p + 1'b1);
  endfunction

  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= entry;
  end

  assert property (@(posedge clk) disable iff (rst)
    push |-> count != CNT_W'(DEPTH))
    else $error("queue overflow");

  assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue underflow");

endmodule

### design/esc_tcs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_tcs_back
// Steps through the queued sequence and frames one command word per cycle
// into the output register while cmd_out is not stalled.
// ----------------------------------------------------------------------------
module esc_tcs_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  esc_tcs_pkg::queue_entry_t  head,
  output logic                       pop,
  esc_tcs_out_if.source              cmd_out
);
  import esc_tcs_pkg::*;

  step_t       step;
  logic        word_valid;
  logic [7:0]  command_code;
  logic [7:0]  parameter_code;
  logic [31:0] data_word;
  logic [7:0]  frame_checksum;
  logic        last_command;

  op_t         op;
  step_t       len;
  logic        last;
  logic        advance;
  logic        load;
  logic        closed;
  logic [7:0]  cmd_w;
  logic [7:0]  pid_w;
  logic [31:0] data_w;
  logic [7:0]  sum_w;

  always_comb begin
    op      = seq_op(head.desc.kind, step);
    len     = seq_len(head.desc.kind);
    last    = (step == step_t'(len - 1'b1));
    advance = !word_valid || cmd_out.ready;
    load    = head_valid && advance;
    pop     = load && last;
    closed  = (head.desc.rng == RANGE_CLOSED);

    unique case (op)
      OP_DISABLE: begin
        cmd_w = CMD_MOTOR_CTRL;  pid_w = PID_NONE;        data_w = '0;
      end
      OP_AUTO: begin
        cmd_w = CMD_PARAM_WRITE; pid_w = PID_AUTO_SWITCH; data_w = 32'(closed);
      end
      OP_DIR: begin
        cmd_w = CMD_PARAM_WRITE; pid_w = PID_REVERSE;     data_w = 32'(head.desc.dir);
      end
      OP_OL: begin
        cmd_w = CMD_PARAM_WRITE; pid_w = PID_OL_SET;      data_w = head.ol;
      end
      OP_CL: begin
        cmd_w = CMD_PARAM_WRITE; pid_w = PID_CL_SET;      data_w = head.cl;
      end
      OP_ENABLE: begin
        cmd_w = CMD_MOTOR_CTRL;  pid_w = PID_NONE;        data_w = {30'd0, closed, 1'b1};
      end
      default: begin
        cmd_w = CMD_MOTOR_CTRL;  pid_w = PID_NONE;        data_w = '0;
      end
    endcase

    // byte sum over the frame, start byte included
    sum_w = FRAME_SYNC + cmd_w + pid_w + data_w[31:24] + data_w[23:16]
          + data_w[15:8] + data_w[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
      step       <= '0;
    end else begin
      if (advance) word_valid <= head_valid;
      if (load)    step <= last ? '0 : step_t'(step + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      command_code   <= cmd_w;
      parameter_code <= pid_w;
      data_word      <= data_w;
      frame_checksum <= sum_w;
      last_command   <= last;
    end
  end

  assign cmd_out.valid          = word_valid;
  assign cmd_out.command_code   = command_code;
  assign cmd_out.parameter_code = parameter_code;
  assign cmd_out.data_word      = data_word;
  assign cmd_out.frame_checksum = frame_checksum;
  assign cmd_out.last_command   = last_command;

  assert property (@(posedge clk) disable iff (rst)
    head_valid |-> step < len)
    else $error("sequence step past its length");

  assert property (@(posedge clk) disable iff (rst)
    head_valid && step != '0 |-> $past(head_valid) && head.desc == $past(head.desc))
    else $error("queue head moved in the middle of a sequence");

endmodule

### design/esc_throttle_command_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_throttle_command_sequencer_top
// Throttle percent in, framed ESC command words out, with register port.
// ----------------------------------------------------------------------------
//  channel       dir  handshake          payload
//  throttle_in   in   valid/ready        throttle_percent
//  cmd_out       out  valid/ready        command_code, parameter_code,
//                                        data_word, frame_checksum, last_command
//  cfg           in   cfg_we, no ready   cfg_index, cfg_data
//
//  input takes one item a cycle while fewer than QUEUE_DEPTH sequences are in flight
//  setpoints pass the scaling pipeline, the queue and the output register before the first word
//  the word sequencer sends one word a cycle while cmd_out is not stalled; an item has 1 to 6 words
//  sustained, the word sequencer sets the item rate; no-word items never occupy it
//  rst is synchronous: state, queue and output cleared, registers to defaults
//  a stalled output holds its word; the queue absorbs it, then input ready drops
// ----------------------------------------------------------------------------
module esc_throttle_command_sequencer_top #(
  parameter int unsigned QUEUE_DEPTH = esc_tcs_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  esc_tcs_in_if.sink                          throttle_in,
  esc_tcs_out_if.source                       cmd_out,
  input  logic                                cfg_we,
  input  logic [esc_tcs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [esc_tcs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import esc_tcs_pkg::*;

  cfg_t         cfg;
  logic         push, pop, head_valid;
  queue_entry_t entry, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadzone     <= DEADZONE_RESET;
      cfg.transition   <= TRANSITION_RESET;
      cfg.closed_max   <= CLOSED_MAX_RESET;
      cfg.closed_floor <= CLOSED_FLOOR_RESET;
      cfg.open_max     <= OPEN_MAX_RESET;
      cfg.open_ceiling <= OPEN_CEILING_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEADZONE:     cfg.deadzone     <= cfg_data[6:0];
        CFG_TRANSITION:   cfg.transition   <= cfg_data[6:0];
        CFG_CLOSED_MAX:   cfg.closed_max   <= cfg_data;
        CFG_CLOSED_FLOOR: cfg.closed_floor <= cfg_data;
        CFG_OPEN_MAX:     cfg.open_max     <= cfg_data;
        CFG_OPEN_CEILING: cfg.open_ceiling <= cfg_data;
        default: ;
      endcase
    end
  end

  esc_tcs_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .throttle_in (throttle_in),
    .cfg         (cfg),
    .pop         (pop),
    .push        (push),
    .entry       (entry)
  );

  esc_tcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .entry      (entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  esc_tcs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .cmd_out    (cmd_out)
  );

endmodule
